FILE: hdl/lsac_pkg.sv
`default_nettype none
package lsac_pkg;

	// fixed field and datapath widths
	localparam int SLOPE_W  = 32;
	localparam int POINT_W  = 24;
	localparam int GAIN_W   = 20;
	localparam int GAIN16_W = 16;
	localparam int SPEED_W  = 4;
	localparam int LIMIT_W  = 7;
	localparam int CFG_W    = 20;
	localparam int IDX_W    = 3;
	localparam int TURN_W   = 8;

	// cordic working widths: vector grows by about 1.65 over a 32 bit input
	localparam int CORDIC_W = 36;
	localparam int ANGLE_W  = 25;
	localparam int ATAN_LEN = 24;
	localparam int CNT_W    = $clog2(ATAN_LEN);

	// error and multiply widths
	localparam int ERR_W  = 25;
	localparam int MB_W   = 27;
	localparam int PROD_W = GAIN_W + MB_W + 1;
	localparam int ACC_W  = PROD_W + 2;
	localparam int FRAC_W = 32;
	localparam int WHOLE_W = ACC_W - FRAC_W;

	localparam logic signed [ANGLE_W-1:0] DEG90_Q16 = ANGLE_W'(5898240);
	localparam logic [CORDIC_W-1:0] ONE_Q16 = CORDIC_W'(65536);
	localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(90);

	// register indexes
	localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [IDX_W-1:0] REG_SPEED     = 3'd3;
	localparam logic [IDX_W-1:0] REG_REF_SLOPE = 3'd4;
	localparam logic [IDX_W-1:0] REG_TURN_LIM  = 3'd5;

	// request kinds
	localparam logic OP_SLOPE = 1'b0;
	localparam logic OP_POINT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_REF_RUN,
		ST_ANG_RUN,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_ROUND,
		ST_CLAMP
	} state_t;

	// cordic request from the sequencer
	typedef struct packed {
		logic                       start;
		logic signed [CORDIC_W-1:0] x0;
		logic signed [CORDIC_W-1:0] y0;
	} cordic_req_t;

	// arctangent table in q.16 degrees, atan(2^-i)
	function automatic logic [21:0] atan_q16(input logic [CNT_W-1:0] i);
		logic [21:0] v;
		unique case (i)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			5'd20:   v = 22'd4;
			5'd21:   v = 22'd2;
			5'd22:   v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/lsac_cordic.sv
`default_nettype none
module lsac_cordic #(
	parameter int STEPS = 16
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  lsac_pkg::cordic_req_t                    req,
	output logic                                     done,
	output logic signed [lsac_pkg::ANGLE_W-1:0]      angle
);

	localparam int CW = lsac_pkg::CORDIC_W;
	localparam int AW = lsac_pkg::ANGLE_W;
	localparam int NW = lsac_pkg::CNT_W;

	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic signed [AW-1:0] z_q, step_ang;
	logic [NW-1:0]        cnt_q;
	logic                 busy_q, done_q;

	// one micro-rotation per cycle, floor shifts
	assign xs       = x_q >>> cnt_q;
	assign ys       = y_q >>> cnt_q;
	assign step_ang = AW'(lsac_pkg::atan_q16(cnt_q));

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= '0;
				if (req.y0 == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (cnt_q == NW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// vector and angle accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= req.x0;
			y_q <= req.y0;
			z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step_ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step_ang;
			end
		end
	end

	// saturate to +/-90 degrees
	always_comb begin
		if (z_q > lsac_pkg::DEG90_Q16) begin
			angle = lsac_pkg::DEG90_Q16;
		end else if (z_q < -lsac_pkg::DEG90_Q16) begin
			angle = -lsac_pkg::DEG90_Q16;
		end else begin
			angle = z_q;
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

FILE: hdl/lsac_mult.sv
`default_nettype none
module lsac_mult (
	input  wire                                     clk,
	input  wire  [lsac_pkg::GAIN_W-1:0]             a,
	input  wire  signed [lsac_pkg::MB_W-1:0]        b,
	output logic signed [lsac_pkg::PROD_W-1:0]      prod_q
);

	// unsigned gain times signed operand, registered
	always_ff @(posedge clk) begin
		prod_q <= $signed({1'b0, a}) * b;
	end

endmodule
`default_nettype wire

FILE: hdl/lane_steering_angle_controller.sv
`default_nettype none
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tuser: operation; tdata: slope, point x, point y
// m_*       out  m_tvalid/m_tready    tdata: turn_angle
// cfg_*     in   cfg_we               cfg_index, cfg_data
//
// a point request runs one arctangent, a slope request two (reference slope, then line
// slope), a zero slope or zero height none; an arctangent whose y is zero ends without
// iterating; the arctangents hold the shared cordic unit, then the shared multiplier runs
// states MUL0 to MUL4, ROUND truncates and CLAMP clamps; s_tready is high only while the
// sequencer is idle; a finished result waits in the output register, the next item is taken
// while it waits; arst_n clears control and previous error and presets the config registers
module lane_steering_angle_controller #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [79:0] s_tdata,   // line_slope[31:0], point_x[55:32], point_y[79:56]
	input  wire         s_tuser,   // operation
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // turn_angle
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [19:0] cfg_data
);

	localparam int STEPS = (CORDIC_STEPS > lsac_pkg::ATAN_LEN) ? lsac_pkg::ATAN_LEN :
		((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
	localparam int CW = lsac_pkg::CORDIC_W;
	localparam int EW = lsac_pkg::ERR_W;
	localparam int BW = lsac_pkg::MB_W;
	localparam int AC = lsac_pkg::ACC_W;
	localparam int WW = lsac_pkg::WHOLE_W;

	localparam logic signed [CW-1:0] ONE_X = lsac_pkg::ONE_Q16;

	lsac_pkg::state_t state_q, state_d;

	// configuration registers
	logic [lsac_pkg::GAIN_W-1:0]   gain_p_q, ref_slope_q;
	logic [lsac_pkg::GAIN16_W-1:0] gain_i_q, gain_d_q;
	logic [lsac_pkg::SPEED_W-1:0]  speed_q;
	logic [lsac_pkg::LIMIT_W-1:0]  limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= 20'd78643;
			gain_i_q    <= 16'd131;
			gain_d_q    <= 16'd197;
			speed_q     <= 4'd6;
			ref_slope_q <= 20'd58982;
			limit_q     <= 7'd44;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lsac_pkg::REG_GAIN_P:    gain_p_q    <= cfg_data;
				lsac_pkg::REG_GAIN_I:    gain_i_q    <= cfg_data[15:0];
				lsac_pkg::REG_GAIN_D:    gain_d_q    <= cfg_data[15:0];
				lsac_pkg::REG_SPEED:     speed_q     <= cfg_data[3:0];
				lsac_pkg::REG_REF_SLOPE: ref_slope_q <= cfg_data;
				lsac_pkg::REG_TURN_LIM:  limit_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// captured request
	logic                                  op_q;
	logic signed [lsac_pkg::SLOPE_W-1:0]   slope_q;
	logic signed [lsac_pkg::POINT_W-1:0]   px_q, py_q;
	logic                                  accept;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser;
			slope_q <= s_tdata[31:0];
			px_q    <= s_tdata[55:32];
			py_q    <= s_tdata[79:56];
		end
	end

	// shared arctangent unit
	lsac_pkg::cordic_req_t              creq;
	logic                               cdone;
	logic signed [lsac_pkg::ANGLE_W-1:0] cangle;

	lsac_cordic #(.STEPS(STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.done   (cdone),
		.angle  (cangle)
	);

	// shared multiplier
	logic [lsac_pkg::GAIN_W-1:0]          mul_a;
	logic signed [BW-1:0]                 mul_b;
	logic signed [lsac_pkg::PROD_W-1:0]   prod_q;

	lsac_mult u_mult (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// datapath registers
	logic signed [EW-1:0] r_q, e_q, prev_q, e_new, e_zero_y;
	logic [lsac_pkg::GAIN_W-1:0] gisp_q;
	logic signed [AC-1:0] acc_q, rnd;
	logic signed [WW-1:0] whole_q, lim_s, clamped;
	logic [lsac_pkg::LIMIT_W-1:0] lim;
	logic signed [CW-1:0] py_abs;
	logic                 out_free;

	assign out_free = !m_tvalid || m_tready;
	assign py_abs   = py_q[lsac_pkg::POINT_W-1] ? -CW'(py_q) : CW'(py_q);

	// error from the finished arctangent
	always_comb begin
		if (op_q == lsac_pkg::OP_SLOPE) begin
			e_new = slope_q[lsac_pkg::SLOPE_W-1] ? (-r_q - EW'(cangle)) : (r_q - EW'(cangle));
		end else begin
			e_new = py_q[lsac_pkg::POINT_W-1] ? -EW'(cangle) : EW'(cangle);
		end
	end

	// zero height: straight left, right, or none
	always_comb begin
		if (px_q == '0) begin
			e_zero_y = '0;
		end else if (px_q[lsac_pkg::POINT_W-1]) begin
			e_zero_y = -EW'(lsac_pkg::DEG90_Q16);
		end else begin
			e_zero_y = EW'(lsac_pkg::DEG90_Q16);
		end
	end

	// truncate toward zero to whole degrees, then clamp
	assign rnd     = acc_q + (acc_q[AC-1] ? AC'(33'h0FFFFFFFF) : AC'(0));
	assign lim     = (limit_q > lsac_pkg::LIMIT_MAX) ? lsac_pkg::LIMIT_MAX : limit_q;
	assign lim_s   = WW'(lim);
	always_comb begin
		if (whole_q > lim_s) begin
			clamped = lim_s;
		end else if (whole_q < -lim_s) begin
			clamped = -lim_s;
		end else begin
			clamped = whole_q;
		end
	end

	// sequencer: next state, cordic requests, multiplier operands
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		creq.start = 1'b0;
		creq.x0    = ONE_X;
		creq.y0    = CW'(ref_slope_q);
		mul_a      = '0;
		mul_b      = '0;
		unique case (state_q)
			lsac_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (accept) state_d = lsac_pkg::ST_DISPATCH;
			end
			lsac_pkg::ST_DISPATCH: begin
				if (op_q == lsac_pkg::OP_SLOPE) begin
					if (slope_q == '0) begin
						state_d = lsac_pkg::ST_MUL0;
					end else begin
						creq.start = 1'b1;
						state_d    = lsac_pkg::ST_REF_RUN;
					end
				end else begin
					creq.x0 = py_abs;
					creq.y0 = CW'(px_q);
					if (py_q == '0) begin
						state_d = lsac_pkg::ST_MUL0;
					end else begin
						creq.start = 1'b1;
						state_d    = lsac_pkg::ST_ANG_RUN;
					end
				end
			end
			lsac_pkg::ST_REF_RUN: begin
				creq.y0 = CW'(slope_q);
				if (cdone) begin
					creq.start = 1'b1;
					state_d    = lsac_pkg::ST_ANG_RUN;
				end
			end
			lsac_pkg::ST_ANG_RUN: begin
				if (cdone) state_d = lsac_pkg::ST_MUL0;
			end
			lsac_pkg::ST_MUL0: begin
				mul_a   = lsac_pkg::GAIN_W'(gain_i_q);
				mul_b   = BW'(speed_q);
				state_d = lsac_pkg::ST_MUL1;
			end
			lsac_pkg::ST_MUL1: begin
				mul_a   = gain_p_q;
				mul_b   = BW'(e_q);
				state_d = lsac_pkg::ST_MUL2;
			end
			lsac_pkg::ST_MUL2: begin
				mul_a   = gisp_q;
				mul_b   = BW'(e_q) + BW'(prev_q);
				state_d = lsac_pkg::ST_MUL3;
			end
			lsac_pkg::ST_MUL3: begin
				mul_a   = lsac_pkg::GAIN_W'(gain_d_q);
				mul_b   = BW'(e_q) - BW'(prev_q);
				state_d = lsac_pkg::ST_MUL4;
			end
			lsac_pkg::ST_MUL4: state_d = lsac_pkg::ST_ROUND;
			lsac_pkg::ST_ROUND: state_d = lsac_pkg::ST_CLAMP;
			lsac_pkg::ST_CLAMP: begin
				if (out_free) state_d = lsac_pkg::ST_IDLE;
			end
			default: state_d = lsac_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// error, product accumulation and whole degrees
	always_ff @(posedge clk) begin
		unique case (state_q)
			lsac_pkg::ST_DISPATCH: begin
				if (op_q == lsac_pkg::OP_SLOPE) begin
					e_q <= prev_q;
				end else begin
					e_q <= e_zero_y;
				end
			end
			lsac_pkg::ST_REF_RUN: begin
				if (cdone) r_q <= EW'(cangle);
			end
			lsac_pkg::ST_ANG_RUN: begin
				if (cdone) e_q <= e_new;
			end
			lsac_pkg::ST_MUL1: gisp_q <= prod_q[lsac_pkg::GAIN_W-1:0];
			lsac_pkg::ST_MUL2: acc_q  <= AC'(prod_q);
			lsac_pkg::ST_MUL3: acc_q  <= acc_q + AC'(prod_q);
			lsac_pkg::ST_MUL4: acc_q  <= acc_q + AC'(prod_q);
			lsac_pkg::ST_ROUND: whole_q <= rnd[AC-1:lsac_pkg::FRAC_W];
			default: ;
		endcase
	end

	// stored previous error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (state_q == lsac_pkg::ST_CLAMP && out_free) begin
			prev_q <= e_q;
		end
	end

	// output register
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == lsac_pkg::ST_CLAMP && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lsac_pkg::ST_CLAMP && out_free) begin
			m_tdata_q <= clamped[lsac_pkg::TURN_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire
